@@ hdl/b64d_pkg.sv @@
// b64d_pkg: shared types, constants and the character map of the base64url decoder.
// No dependencies; imported by b64d_decode and base64url_stream_decoder.
package b64d_pkg;

   localparam int CapBits = 24;
   localparam logic [CapBits-1:0] CapReset = 24'd1048640;

   localparam logic [6:0] SextetInvalid = 7'd64;
   localparam logic [6:0] SextetDash = 7'd62;
   localparam logic [6:0] SextetUnderscore = 7'd63;
   localparam logic [6:0] LowerBase = 7'd26;
   localparam logic [6:0] DigitBase = 7'd52;

   // pending group of up to three sextets, newest in the low bits
   typedef struct packed {
      logic [17:0] sextets;
      logic [1:0] fill;
      logic skipping;
   } group_state_type;

   // up to three results caused by one character; bytes[0] goes out first
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0] count;
      logic error;
      logic last;
   } result_set_type;

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = SextetInvalid;
      if (c >= 8'h41 && c <= 8'h5a) begin            // A..Z
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin   // a..z
         v = 7'(c - 8'h61) + LowerBase;
      end else if (c >= 8'h30 && c <= 8'h39) begin   // 0..9
         v = 7'(c - 8'h30) + DigitBase;
      end else if (c == 8'h2d) begin                 // '-'
         v = SextetDash;
      end else if (c == 8'h5f) begin                 // '_'
         v = SextetUnderscore;
      end
      return v;
   endfunction

endpackage

@@ hdl/b64d_decode.sv @@
// b64d_decode: combinational decode of one character against the group state.
// Depends on b64d_pkg.
module b64d_decode #(
   parameter int COUNT_BITS = 24
) (
   input  logic [7:0]                      in_char,
   input  logic                            in_last,
   input  b64d_pkg::group_state_type       state_cur,
   input  logic [COUNT_BITS-1:0]           emitted_cur,
   input  logic [b64d_pkg::CapBits-1:0]    capacity,
   output b64d_pkg::group_state_type       state_nxt,
   output logic [COUNT_BITS-1:0]           emitted_nxt,
   output b64d_pkg::result_set_type        results
);
   import b64d_pkg::*;

   localparam int CW = (COUNT_BITS > CapBits) ? COUNT_BITS : CapBits;
   localparam logic [CW:0] CountMax =
      {{(CW + 1 - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

   logic [6:0]  sextet;
   logic [23:0] acc;
   logic [2:0]  cnt;
   logic [1:0]  need;
   logic [CW:0] cap_ext;
   logic [CW:0] cap_eff;
   logic [CW:0] total;
   logic        fail;
   logic        emit;
   logic [2:0][7:0] bytes;

   assign sextet  = sextet_of(in_char);
   assign acc     = {state_cur.sextets, sextet[5:0]};
   assign cnt     = {1'b0, state_cur.fill} + 3'd1;
   assign cap_ext = (CW + 1)'(capacity);
   assign cap_eff = (cap_ext < CountMax) ? cap_ext : CountMax;
   assign total   = (CW + 1)'(emitted_cur) + (CW + 1)'(need);

   always_comb begin
      need  = 2'd0;
      bytes = '0;
      emit  = 1'b0;
      fail  = 1'b0;
      if (sextet == SextetInvalid) begin
         fail = 1'b1;
      end else if (cnt == 3'd4) begin
         need  = 2'd3;
         emit  = 1'b1;
         bytes = {acc[7:0], acc[15:8], acc[23:16]};
      end else if (in_last) begin
         if (cnt == 3'd1) begin
            fail = 1'b1;
         end else if (cnt == 3'd2) begin
            need  = 2'd1;
            emit  = 1'b1;
            bytes = {8'h00, 8'h00, acc[11:4]};
         end else begin
            need  = 2'd2;
            emit  = 1'b1;
            bytes = {8'h00, acc[9:2], acc[17:10]};
         end
      end
      if (emit && total > cap_eff) begin
         fail = 1'b1;
         emit = 1'b0;
      end
   end

   always_comb begin
      state_nxt   = state_cur;
      emitted_nxt = emitted_cur;
      results     = '0;
      if (state_cur.skipping) begin
         if (in_last) begin
            state_nxt   = '0;
            emitted_nxt = '0;
         end
      end else if (fail) begin
         state_nxt          = '0;
         state_nxt.skipping = ~in_last;
         emitted_nxt        = '0;
         results.count      = 2'd1;
         results.error      = 1'b1;
         results.last       = 1'b1;
      end else if (emit) begin
         state_nxt     = '0;
         emitted_nxt   = in_last ? '0 : total[COUNT_BITS-1:0];
         results.bytes = bytes;
         results.count = need;
         results.last  = in_last;
      end else begin
         state_nxt.sextets = acc[17:0];
         state_nxt.fill    = cnt[1:0];
      end
   end

endmodule

@@ hdl/base64url_stream_decoder.sv @@
// Each input-stage character decodes combinationally; its results register as it advances.
// Throughput: one character per cycle; results leave one per rsp transaction, up to three
// per character. A second result-set register takes a new set while the three bytes of a
// group still drain, so the input stalls only when both hold results, i.e. when results
// come faster than one per cycle or the receiver stalls.
// Reset (synchronous): empties all stages, clears group state, capacity to 1048640.
// base64url_stream_decoder: top level; depends on b64d_pkg and b64d_decode.
module base64url_stream_decoder #(
   parameter int COUNT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // character stream
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_char,
   input  logic                          req_in_last,
   // decoded bytes
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_out_error,
   output logic                          rsp_out_last,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [b64d_pkg::CapBits-1:0]  csr_output_capacity
);
   import b64d_pkg::*;

   // capacity register
   logic [CapBits-1:0] cap_ff, cap_in;

   // input stage
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_char_ff, a_char_in;
   logic       a_last_ff, a_last_in;

   // stream state
   group_state_type        st_ff, st_in, st_dec;
   logic [COUNT_BITS-1:0]  emitted_ff, emitted_in, emitted_dec;

   // result buffer; count is the number of results still to leave
   result_set_type buf_ff, buf_in;
   // next result set, waiting for the buffer to empty
   result_set_type hold_ff, hold_in;
   result_set_type dec_res;

   logic req_take;
   logic rsp_take;
   logic buf_free;
   logic hold_free;
   logic direct;
   logic advance;

   b64d_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .in_char     (a_char_ff),
      .in_last     (a_last_ff),
      .state_cur   (st_ff),
      .emitted_cur (emitted_ff),
      .capacity    (cap_ff),
      .state_nxt   (st_dec),
      .emitted_nxt (emitted_dec),
      .results     (dec_res)
   );

   // Handshakes. User keeps register writes to idle times; not enforced, so always ready.
   assign csr_ready = 1'b1;
   assign rsp_valid = (buf_ff.count != 2'd0);
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // Buffer can take a new result set when empty or when its final entry leaves now.
   assign buf_free  = (buf_ff.count == 2'd0) || (rsp_take && buf_ff.count == 2'd1);
   // Hold register is free when empty or when its set moves to the buffer now.
   assign hold_free = (hold_ff.count == 2'd0) || buf_free;
   // A character that causes no result never waits on the output side.
   assign advance   = a_valid_ff && (dec_res.count == 2'd0 || hold_free);
   // fresh results skip the hold register when nothing is queued ahead of them
   assign direct    = advance && dec_res.count != 2'd0 && buf_free &&
                      hold_ff.count == 2'd0;
   assign req_stall = a_valid_ff & ~advance;

   assign rsp_out_byte  = buf_ff.bytes[0];
   assign rsp_out_error = buf_ff.error;
   assign rsp_out_last  = buf_ff.last && (buf_ff.count == 2'd1);

   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_output_capacity;
      end

      a_valid_in = a_valid_ff & ~advance;
      a_char_in  = a_char_ff;
      a_last_in  = a_last_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
         a_char_in  = req_in_char;
         a_last_in  = req_in_last;
      end

      st_in      = st_ff;
      emitted_in = emitted_ff;
      if (advance) begin
         st_in      = st_dec;
         emitted_in = emitted_dec;
      end

      buf_in = buf_ff;
      if (buf_free && hold_ff.count != 2'd0) begin
         buf_in = hold_ff;
      end else if (direct) begin
         buf_in = dec_res;
      end else if (rsp_take) begin
         // shift the next byte to the head
         buf_in.bytes = {8'h00, buf_ff.bytes[2], buf_ff.bytes[1]};
         buf_in.count = buf_ff.count - 2'd1;
      end

      hold_in = hold_ff;
      if (buf_free) begin
         hold_in = '0;
      end
      if (advance && dec_res.count != 2'd0 && !direct) begin
         hold_in = dec_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CapReset;
         a_valid_ff <= 1'b0;
         st_ff      <= '0;
         emitted_ff <= '0;
         buf_ff     <= '0;
         hold_ff    <= '0;
      end else begin
         cap_ff     <= cap_in;
         a_valid_ff <= a_valid_in;
         st_ff      <= st_in;
         emitted_ff <= emitted_in;
         buf_ff     <= buf_in;
         hold_ff    <= hold_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      a_char_ff <= a_char_in;
      a_last_ff <= a_last_in;
   end

   // error results are single, zero and terminate the stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_error |-> rsp_out_last && rsp_out_byte == 8'h00 &&
                                     buf_ff.count == 2'd1)
      else $error("error result malformed");

   // while skipping no group or byte count is kept
   assert property (@(posedge clock) disable iff (reset)
      st_ff.skipping |-> st_ff.fill == 2'd0 && emitted_ff == '0)
      else $error("state left over while skipping");

   // a character that decodes to results has them queued in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance && dec_res.count != 2'd0 |=> rsp_valid &&
         (buf_ff.count == $past(dec_res.count) || hold_ff.count == $past(dec_res.count)))
      else $error("decoded results not loaded");

   // the hold register only fills behind a busy buffer
   assert property (@(posedge clock) disable iff (reset)
      hold_ff.count != 2'd0 |-> buf_ff.count != 2'd0)
      else $error("held results with empty buffer");

   // the input stage never drops a pending character
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !advance |=> a_valid_ff && $stable(a_char_ff) && $stable(a_last_ff))
      else $error("pending character lost");

endmodule
